>>> sv/cbrw_pkg.sv
package cbrw_pkg;

   // defaults for the top level parameters
   localparam int MAX_KERNEL_DEF = 7;
   localparam int MAX_WIDTH_DEF  = 1024;

   // fixed field widths
   localparam int SAMPLE_W   = 16;
   localparam int KSIZE_W    = 3;
   localparam int FWIDTH_W   = 11;
   localparam int BIAS_W     = 16;
   localparam int WIDX_W     = 6;
   localparam int ACT_W      = 15;
   localparam int POS_W      = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int PROD_W     = 2 * SAMPLE_W;
   localparam int FRAC_BITS  = 12;

   localparam logic [KSIZE_W-1:0]  KSIZE_RST  = 3'd3;
   localparam logic [FWIDTH_W-1:0] FWIDTH_RST = 11'd1024;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KERNEL_SIZE = 2'd0,
      CSR_FRAME_WIDTH = 2'd1,
      CSR_BIAS_VALUE  = 2'd2
   } csr_index_type;

   typedef enum logic {
      ACT_WEIGHT = 1'b0,
      ACT_PIXEL  = 1'b1
   } action_type;

   // travels down the pipeline next to the data of one pixel
   typedef struct packed {
      logic             emit;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
   } tag_type;

   // width of one kernel row sum
   function automatic int row_width(int mk);
      return PROD_W + $clog2(mk);
   endfunction

   // width of the full window sum plus bias
   function automatic int sum_width(int mk);
      return PROD_W + 2 * $clog2(mk) + 1;
   endfunction

endpackage

>>> sv/conv2d_bias_relu_window_core.sv
// Channel    Ports                                           Direction
// request    req_valid/req_ready, action, weight_index,      in
//            sample, frame_start
// response   rsp_valid/rsp_ready, activation, out_row,       out
//            out_col
// csr        csr_wr_en, csr_index, csr_wr_data               in
//
// One transaction per cycle while req_ready is high; a result shows on
// rsp_valid after the input, window, product, row sum and total stages.
// Reset clears counters, window and csr defaults; line buffers and weights
// hold whatever they had until written.
// The pipeline freezes only when the output register is full, not taken,
// and the last sum stage holds another result.
module conv2d_bias_relu_window_core #(
   parameter int MAX_KERNEL = cbrw_pkg::MAX_KERNEL_DEF,
   parameter int MAX_WIDTH  = cbrw_pkg::MAX_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_action,
   input  logic [cbrw_pkg::WIDX_W-1:0]           req_weight_index,
   input  logic signed [cbrw_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic                                  req_frame_start,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [cbrw_pkg::ACT_W-1:0]            rsp_activation,
   output logic [cbrw_pkg::POS_W-1:0]            rsp_out_row,
   output logic [cbrw_pkg::POS_W-1:0]            rsp_out_col,
   input  logic                                  csr_wr_en,
   input  logic [cbrw_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [cbrw_pkg::CSR_DATA_W-1:0]       csr_wr_data
);

   localparam int SW   = cbrw_pkg::SAMPLE_W;
   localparam int POSW = cbrw_pkg::POS_W;
   localparam int ACTW = cbrw_pkg::ACT_W;
   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int EW   = (CW + 1 > cbrw_pkg::FWIDTH_W) ? CW + 1 : cbrw_pkg::FWIDTH_W;
   localparam int KW   = $clog2(MAX_KERNEL + 1);
   localparam int KEW  = (KW > cbrw_pkg::KSIZE_W) ? KW : cbrw_pkg::KSIZE_W;
   localparam int TW   = cbrw_pkg::sum_width(MAX_KERNEL);
   localparam int NW   = MAX_KERNEL * MAX_KERNEL;

   // csr
   logic [cbrw_pkg::KSIZE_W-1:0]      kernel_size_ff;
   logic [cbrw_pkg::FWIDTH_W-1:0]     frame_width_ff;
   logic signed [cbrw_pkg::BIAS_W-1:0] bias_ff;

   logic [KEW-1:0]  ksz_ext;
   logic [KEW-1:0]  k_eff;
   logic [KEW-1:0]  km1;
   logic [EW-1:0]   fw_ext;
   logic [EW-1:0]   w_eff;

   // handshake and position
   logic            adv;
   logic            accept;
   logic            pix_fire;
   logic [POSW-1:0] row_ff, row_in, r_cur;
   logic [CW-1:0]   col_ff, col_in, c_cur;
   logic [EW-1:0]   c_ext;
   logic            row_end;

   // input stage
   logic                      a_pix_ff;
   logic                      a_wt_ff;
   logic signed [SW-1:0]      a_sample_ff;
   logic [cbrw_pkg::WIDX_W-1:0] a_widx_ff;
   logic [CW-1:0]             a_col_ff;
   cbrw_pkg::tag_type         a_tag_ff, a_tag_in, b_tag_in;

   logic signed [SW-1:0]              taps [MAX_KERNEL];
   logic signed [cbrw_pkg::PROD_W-1:0] prod [NW];
   cbrw_pkg::tag_type                 prod_tag;
   logic signed [TW-1:0]              total;
   logic signed [TW-1:0]              shifted;
   cbrw_pkg::tag_type                 tot_tag;

   // output register
   logic               rsp_valid_ff;
   logic [ACTW-1:0]    act_ff, act_in;
   logic [POSW-1:0]    out_row_ff, out_col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_size_ff <= cbrw_pkg::KSIZE_RST;
         frame_width_ff <= cbrw_pkg::FWIDTH_RST;
         bias_ff        <= '0;
      end else if (csr_wr_en) begin
         unique case (cbrw_pkg::csr_index_type'(csr_index))
            cbrw_pkg::CSR_KERNEL_SIZE: begin
               kernel_size_ff <= csr_wr_data[cbrw_pkg::KSIZE_W-1:0];
            end
            cbrw_pkg::CSR_FRAME_WIDTH: begin
               frame_width_ff <= csr_wr_data[cbrw_pkg::FWIDTH_W-1:0];
            end
            cbrw_pkg::CSR_BIAS_VALUE: begin
               bias_ff <= csr_wr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // zero means one, oversize clamps to the built maximum
   always_comb begin
      ksz_ext = KEW'(kernel_size_ff);
      priority if (ksz_ext == '0) begin
         k_eff = KEW'(1);
      end else if (ksz_ext > KEW'(MAX_KERNEL)) begin
         k_eff = KEW'(MAX_KERNEL);
      end else begin
         k_eff = ksz_ext;
      end
      km1 = k_eff - KEW'(1);

      fw_ext = EW'(frame_width_ff);
      priority if (fw_ext == '0) begin
         w_eff = EW'(1);
      end else if (fw_ext > EW'(MAX_WIDTH)) begin
         w_eff = EW'(MAX_WIDTH);
      end else begin
         w_eff = fw_ext;
      end
   end

   assign adv       = !(rsp_valid_ff && !rsp_ready && tot_tag.emit);
   assign req_ready = adv;
   assign accept    = req_valid && adv;
   assign pix_fire  = accept && (req_action == cbrw_pkg::ACT_PIXEL);

   always_comb begin
      r_cur   = req_frame_start ? '0 : row_ff;
      c_cur   = req_frame_start ? '0 : col_ff;
      c_ext   = EW'(c_cur);
      row_end = (c_ext + EW'(1)) >= w_eff;

      a_tag_in.emit = (r_cur >= POSW'(km1)) && (c_ext >= EW'(km1));
      a_tag_in.row  = r_cur - POSW'(km1);
      a_tag_in.col  = POSW'(c_ext - EW'(km1));

      if (row_end) begin
         row_in = r_cur + POSW'(1);
         col_in = '0;
      end else begin
         row_in = r_cur;
         col_in = c_cur + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (pix_fire) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_pix_ff <= 1'b0;
         a_wt_ff  <= 1'b0;
      end else if (adv) begin
         a_pix_ff <= pix_fire;
         a_wt_ff  <= accept && (req_action == cbrw_pkg::ACT_WEIGHT);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_sample_ff <= req_sample;
         a_widx_ff   <= req_weight_index;
         a_col_ff    <= c_cur;
         a_tag_ff    <= a_tag_in;
      end
   end

   always_comb begin
      b_tag_in      = a_tag_ff;
      b_tag_in.emit = a_pix_ff && a_tag_ff.emit;
   end

   cbrw_linebuf #(
      .MAX_KERNEL (MAX_KERNEL),
      .MAX_WIDTH  (MAX_WIDTH)
   ) u_linebuf (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .rd_en     (pix_fire),
      .rd_col    (c_cur),
      .wr_en     (a_pix_ff),
      .wr_col    (a_col_ff),
      .wr_sample (a_sample_ff),
      .taps      (taps)
   );

   cbrw_window #(
      .MAX_KERNEL (MAX_KERNEL)
   ) u_window (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .shift_en (a_pix_ff),
      .taps     (taps),
      .wt_wr_en (a_wt_ff),
      .wt_index (a_widx_ff),
      .wt_data  (a_sample_ff),
      .k        (k_eff[KW-1:0]),
      .tag_in   (b_tag_in),
      .prod     (prod),
      .prod_tag (prod_tag)
   );

   cbrw_sum #(
      .MAX_KERNEL (MAX_KERNEL)
   ) u_sum (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .prod      (prod),
      .prod_tag  (prod_tag),
      .bias      (bias_ff),
      .total     (total),
      .total_tag (tot_tag)
   );

   // ReLU, drop the fraction, saturate
   always_comb begin
      shifted = total >>> cbrw_pkg::FRAC_BITS;
      if (total[TW-1] || (total == '0)) begin
         act_in = '0;
      end else if (|shifted[TW-1:ACTW]) begin
         act_in = '1;
      end else begin
         act_in = shifted[ACTW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv && tot_tag.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && tot_tag.emit) begin
         act_ff     <= act_in;
         out_row_ff <= tot_tag.row;
         out_col_ff <= tot_tag.col;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_activation = act_ff;
   assign rsp_out_row    = out_row_ff;
   assign rsp_out_col    = out_col_ff;

endmodule

>>> sv/cbrw_linebuf.sv
module cbrw_linebuf #(
   parameter int MAX_KERNEL = cbrw_pkg::MAX_KERNEL_DEF,
   parameter int MAX_WIDTH  = cbrw_pkg::MAX_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  adv,
   input  logic                                  rd_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]          rd_col,
   input  logic                                  wr_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]          wr_col,
   input  logic signed [cbrw_pkg::SAMPLE_W-1:0]  wr_sample,
   output logic signed [cbrw_pkg::SAMPLE_W-1:0]  taps [MAX_KERNEL]
);

   localparam int SW = cbrw_pkg::SAMPLE_W;

   generate
      if (MAX_KERNEL > 1) begin : g_lines
         localparam int NL = MAX_KERNEL - 1;

         logic signed [SW-1:0] rd_ff       [NL];
         logic signed [SW-1:0] byp_data_ff [NL];
         logic signed [SW-1:0] line_eff    [NL];
         logic signed [SW-1:0] wr_data     [NL];
         logic                 byp_ff;

         // the write of the older pixel lands on the edge the newer one reads;
         // same column means the read data is stale and gets replaced
         always_ff @(posedge clock) begin
            if (reset) begin
               byp_ff <= 1'b0;
            end else if (adv) begin
               byp_ff <= rd_en && wr_en && (rd_col == wr_col);
            end
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               byp_data_ff <= wr_data;
            end
         end

         always_comb begin
            for (int j = 0; j < NL; j++) begin
               line_eff[j] = byp_ff ? byp_data_ff[j] : rd_ff[j];
               wr_data[j]  = (j == 0) ? wr_sample : line_eff[(j > 0) ? j - 1 : 0];
            end
            taps[MAX_KERNEL-1] = wr_sample;
            for (int j = 0; j < NL; j++) begin
               taps[MAX_KERNEL-2-j] = line_eff[j];
            end
         end

         for (genvar j = 0; j < NL; j++) begin : g_mem
            logic signed [SW-1:0] mem [MAX_WIDTH];

            always_ff @(posedge clock) begin
               if (rd_en) begin
                  rd_ff[j] <= mem[rd_col];
               end
               if (adv && wr_en) begin
                  mem[wr_col] <= wr_data[j];
               end
            end
         end
      end else begin : g_nolines
         assign taps[0] = wr_sample;
      end
   endgenerate

endmodule

>>> sv/cbrw_window.sv
module cbrw_window #(
   parameter int MAX_KERNEL = cbrw_pkg::MAX_KERNEL_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  adv,
   input  logic                                  shift_en,
   input  logic signed [cbrw_pkg::SAMPLE_W-1:0]  taps [MAX_KERNEL],
   input  logic                                  wt_wr_en,
   input  logic [cbrw_pkg::WIDX_W-1:0]           wt_index,
   input  logic signed [cbrw_pkg::SAMPLE_W-1:0]  wt_data,
   input  logic [$clog2(MAX_KERNEL+1)-1:0]       k,
   input  cbrw_pkg::tag_type                     tag_in,
   output logic signed [cbrw_pkg::PROD_W-1:0]    prod [MAX_KERNEL*MAX_KERNEL],
   output cbrw_pkg::tag_type                     prod_tag
);

   localparam int SW  = cbrw_pkg::SAMPLE_W;
   localparam int PW  = cbrw_pkg::PROD_W;
   localparam int NW  = MAX_KERNEL * MAX_KERNEL;
   localparam int WIW = (NW > 1) ? $clog2(NW) : 1;
   localparam int IXW = (WIW > cbrw_pkg::WIDX_W) ? WIW : cbrw_pkg::WIDX_W;

   logic signed [SW-1:0] weight_store [NW];
   logic signed [SW-1:0] win_ff [MAX_KERNEL][MAX_KERNEL];
   logic signed [SW-1:0] wsel   [NW];
   logic signed [PW-1:0] prod_c [NW];
   logic signed [PW-1:0] prod_ff [NW];
   logic [IXW-1:0]       widx_ext;
   cbrw_pkg::tag_type    b_tag_ff;
   cbrw_pkg::tag_type    prod_tag_ff;

   assign widx_ext = IXW'(wt_index);

   always_ff @(posedge clock) begin
      if (adv && wt_wr_en && (widx_ext < IXW'(NW))) begin
         weight_store[widx_ext[WIW-1:0]] <= wt_data;
      end
   end

   // newest column enters on the right, oldest row at the top
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < MAX_KERNEL; r++) begin
            for (int c = 0; c < MAX_KERNEL; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else if (adv && shift_en) begin
         for (int r = 0; r < MAX_KERNEL; r++) begin
            for (int c = 0; c + 1 < MAX_KERNEL; c++) begin
               win_ff[r][c] <= win_ff[r][c+1];
            end
            win_ff[r][MAX_KERNEL-1] <= taps[r];
         end
      end
   end

   // the active KxK sits in the bottom right corner; weights follow row*K+col
   always_comb begin
      int base;
      int ri;
      int ci;
      base = MAX_KERNEL - int'(k);
      for (int pr = 0; pr < MAX_KERNEL; pr++) begin
         for (int pc = 0; pc < MAX_KERNEL; pc++) begin
            ri = pr - base;
            ci = pc - base;
            if (ri >= 0 && ci >= 0) begin
               wsel[pr*MAX_KERNEL+pc] = weight_store[WIW'(ri * int'(k) + ci)];
            end else begin
               wsel[pr*MAX_KERNEL+pc] = '0;
            end
            prod_c[pr*MAX_KERNEL+pc] = win_ff[pr][pc] * wsel[pr*MAX_KERNEL+pc];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_tag_ff.emit    <= 1'b0;
         prod_tag_ff.emit <= 1'b0;
      end else if (adv) begin
         b_tag_ff    <= tag_in;
         prod_tag_ff <= b_tag_ff;
      end
   end

   assign prod     = prod_ff;
   assign prod_tag = prod_tag_ff;

endmodule

>>> sv/cbrw_sum.sv
module cbrw_sum #(
   parameter int MAX_KERNEL = cbrw_pkg::MAX_KERNEL_DEF
) (
   input  logic                                                 clock,
   input  logic                                                 reset,
   input  logic                                                 adv,
   input  logic signed [cbrw_pkg::PROD_W-1:0]                   prod [MAX_KERNEL*MAX_KERNEL],
   input  cbrw_pkg::tag_type                                    prod_tag,
   input  logic signed [cbrw_pkg::BIAS_W-1:0]                   bias,
   output logic signed [cbrw_pkg::sum_width(MAX_KERNEL)-1:0]    total,
   output cbrw_pkg::tag_type                                    total_tag
);

   localparam int RW = cbrw_pkg::row_width(MAX_KERNEL);
   localparam int TW = cbrw_pkg::sum_width(MAX_KERNEL);

   logic signed [RW-1:0] row_c  [MAX_KERNEL];
   logic signed [RW-1:0] row_ff [MAX_KERNEL];
   logic signed [TW-1:0] total_c;
   logic signed [TW-1:0] total_ff;
   cbrw_pkg::tag_type    row_tag_ff;
   cbrw_pkg::tag_type    total_tag_ff;

   always_comb begin
      for (int r = 0; r < MAX_KERNEL; r++) begin
         row_c[r] = '0;
         for (int c = 0; c < MAX_KERNEL; c++) begin
            row_c[r] = row_c[r] + RW'(prod[r*MAX_KERNEL+c]);
         end
      end
   end

   always_comb begin
      total_c = TW'(bias) <<< cbrw_pkg::FRAC_BITS;
      for (int r = 0; r < MAX_KERNEL; r++) begin
         total_c = total_c + TW'(row_ff[r]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         row_ff   <= row_c;
         total_ff <= total_c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_tag_ff.emit   <= 1'b0;
         total_tag_ff.emit <= 1'b0;
      end else if (adv) begin
         row_tag_ff   <= prod_tag;
         total_tag_ff <= row_tag_ff;
      end
   end

   assign total     = total_ff;
   assign total_tag = total_tag_ff;

endmodule
